FILE: sv/hscc_pkg.sv
package hscc_pkg;

    // default width of the pulse, window, period and speed counters
    localparam int COUNT_WIDTH_DEF = 16;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_CNT_W  = 16;
    localparam int DUTY_W     = 8;
    localparam int STEP_W     = 4;
    localparam int CMD_W      = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART_DUTY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_UP_STEP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DOWN_STEP = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_DUTY    = 3'd7;

    // register reset values
    localparam logic [CFG_CNT_W-1:0] MEASURE_WINDOW_RST = 16'd25000;
    localparam logic [CFG_CNT_W-1:0] CONTROL_PERIOD_RST = 16'd25000;
    localparam logic [DUTY_W-1:0]    RESTART_DUTY_RST   = 8'd230;
    localparam logic [DUTY_W-1:0]    DUTY_FLOOR_RST     = 8'd4;
    localparam logic [DUTY_W-1:0]    DUTY_CEILING_RST   = 8'd240;
    localparam logic [STEP_W-1:0]    SPEED_UP_STEP_RST  = 4'd3;
    localparam logic [STEP_W-1:0]    SLOW_DOWN_STEP_RST = 4'd2;
    localparam logic [DUTY_W-1:0]    MANUAL_DUTY_RST    = 8'd150;

    // command codes
    localparam logic [CMD_W-1:0] CMD_OFF     = 8'd240;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 8'd254;
    localparam logic [CMD_W-1:0] CMD_FORWARD = 8'd253;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_OFF     = 2'd1,
        ACT_REVERSE = 2'd2,
        ACT_FORWARD = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_CTRL = 2'd1,
        PH_RECV = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CFG_CNT_W-1:0] measure_window;
        logic [CFG_CNT_W-1:0] control_period;
        logic [DUTY_W-1:0]    restart_duty;
        logic [DUTY_W-1:0]    duty_floor;
        logic [DUTY_W-1:0]    duty_ceiling;
        logic [STEP_W-1:0]    speed_up_step;
        logic [STEP_W-1:0]    slow_down_step;
        logic [DUTY_W-1:0]    manual_duty;
    } cfg_t;

    typedef struct packed {
        action_t           motor_action;
        logic [DUTY_W-1:0] motor_duty;
        logic              report_valid;
        logic [7:0]        speed_report;
    } result_t;

endpackage

FILE: sv/hscc_if.sv
interface hscc_tick_if;
    import hscc_pkg::*;

    logic             valid;
    logic             ready;
    logic             hall_level;
    logic             cmd_valid;
    logic [CMD_W-1:0] cmd_byte;

    modport source (output valid, hall_level, cmd_valid, cmd_byte, input ready);
    modport sink   (input valid, hall_level, cmd_valid, cmd_byte, output ready);
endinterface

interface hscc_result_if;
    import hscc_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        motor_action;
    logic [DUTY_W-1:0] motor_duty;
    logic              report_valid;
    logic [7:0]        speed_report;

    modport source (output valid, motor_action, motor_duty, report_valid, speed_report,
                    input ready);
    modport sink   (input valid, motor_action, motor_duty, report_valid, speed_report,
                    output ready);
endinterface

FILE: sv/hscc_cfg_regs.sv
module hscc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [hscc_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [hscc_pkg::CFG_DATA_W-1:0]  wr_data,
    output hscc_pkg::cfg_t                   cfg
);
    import hscc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_MEASURE_WINDOW: cfg_next.measure_window = wr_data;
                REG_CONTROL_PERIOD: cfg_next.control_period = wr_data;
                REG_RESTART_DUTY:   cfg_next.restart_duty   = wr_data[DUTY_W-1:0];
                REG_DUTY_FLOOR:     cfg_next.duty_floor     = wr_data[DUTY_W-1:0];
                REG_DUTY_CEILING:   cfg_next.duty_ceiling   = wr_data[DUTY_W-1:0];
                REG_SPEED_UP_STEP:  cfg_next.speed_up_step  = wr_data[STEP_W-1:0];
                REG_SLOW_DOWN_STEP: cfg_next.slow_down_step = wr_data[STEP_W-1:0];
                REG_MANUAL_DUTY:    cfg_next.manual_duty    = wr_data[DUTY_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.measure_window <= MEASURE_WINDOW_RST;
            cfg_reg.control_period <= CONTROL_PERIOD_RST;
            cfg_reg.restart_duty   <= RESTART_DUTY_RST;
            cfg_reg.duty_floor     <= DUTY_FLOOR_RST;
            cfg_reg.duty_ceiling   <= DUTY_CEILING_RST;
            cfg_reg.speed_up_step  <= SPEED_UP_STEP_RST;
            cfg_reg.slow_down_step <= SLOW_DOWN_STEP_RST;
            cfg_reg.manual_duty    <= MANUAL_DUTY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/hscc_speed_meter.sv
module hscc_speed_meter #(
    parameter int COUNT_WIDTH = hscc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic                            hall_level,
    input  logic [hscc_pkg::CFG_CNT_W-1:0]  measure_window,
    output logic [COUNT_WIDTH-1:0]          speed_now
);
    import hscc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_CNT_W) ? COUNT_WIDTH : CFG_CNT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic                   hall_was_high_reg, hall_was_high_next;
    logic [COUNT_WIDTH-1:0] pulse_count_reg, pulse_count_next;
    logic [COUNT_WIDTH-1:0] window_count_reg, window_count_next;
    logic                   window_due_reg, window_due_next;
    logic [COUNT_WIDTH-1:0] speed_reg, speed_next;
    logic [COUNT_WIDTH-1:0] pulse_edge;

    always_comb
    begin
        // falling edge of the hall level, saturating
        pulse_edge = pulse_count_reg;
        if (!hall_level && hall_was_high_reg && pulse_count_reg != CNT_MAX)
        begin
            pulse_edge = pulse_count_reg + 1'b1;
        end

        hall_was_high_next = hall_was_high_reg;
        pulse_count_next   = pulse_count_reg;
        window_count_next  = window_count_reg;
        window_due_next    = window_due_reg;
        speed_next         = speed_reg;

        if (step)
        begin
            hall_was_high_next = hall_level;
            if (!window_due_reg)
            begin
                pulse_count_next = pulse_edge;
                if (CMP_W'(window_count_reg) < CMP_W'(measure_window)
                    && window_count_reg != CNT_MAX)
                begin
                    window_count_next = window_count_reg + 1'b1;
                end
                else
                begin
                    window_due_next = 1'b1;
                end
            end
            else
            begin
                speed_next        = pulse_edge;
                pulse_count_next  = '0;
                window_count_next = '0;
                window_due_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hall_was_high_reg <= 1'b0;
            pulse_count_reg   <= '0;
            window_count_reg  <= '0;
            window_due_reg    <= 1'b0;
            speed_reg         <= '0;
        end
        else
        begin
            hall_was_high_reg <= hall_was_high_next;
            pulse_count_reg   <= pulse_count_next;
            window_count_reg  <= window_count_next;
            window_due_reg    <= window_due_next;
            speed_reg         <= speed_next;
        end
    end

    // the drive step of the same tick sees the freshly latched speed
    assign speed_now = window_due_reg ? pulse_edge : speed_reg;

endmodule

FILE: sv/hscc_drive_ctrl.sv
module hscc_drive_ctrl #(
    parameter int COUNT_WIDTH = hscc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        cmd_valid,
    input  logic [hscc_pkg::CMD_W-1:0]  cmd_byte,
    input  hscc_pkg::cfg_t              cfg,
    input  logic [COUNT_WIDTH-1:0]      speed_now,
    output hscc_pkg::result_t           res
);
    import hscc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_CNT_W) ? COUNT_WIDTH : CFG_CNT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] period_count_reg, period_count_next;
    logic [CMD_W-1:0]       held_cmd_reg, held_cmd_next;
    logic [DUTY_W-1:0]      duty_reg, duty_next;

    logic [COUNT_WIDTH-1:0] target;
    logic [DUTY_W-1:0]      clamped;
    logic [DUTY_W-1:0]      stepped;
    logic [DUTY_W:0]        slow_sum;
    logic [DUTY_W-1:0]      up_step;

    // duty path of a closed-loop control step
    always_comb
    begin
        target   = COUNT_WIDTH'(held_cmd_reg[CMD_W-1:2]);
        up_step  = DUTY_W'(cfg.speed_up_step);
        if (duty_reg < cfg.duty_floor)
        begin
            clamped = cfg.duty_floor;
        end
        else if (duty_reg > cfg.duty_ceiling)
        begin
            clamped = cfg.duty_ceiling;
        end
        else
        begin
            clamped = duty_reg;
        end
        slow_sum = {1'b0, clamped} + (DUTY_W+1)'(cfg.slow_down_step);
        if (target > speed_now)
        begin
            stepped = (clamped > up_step) ? clamped - up_step : '0;
        end
        else if (target < speed_now)
        begin
            stepped = slow_sum[DUTY_W] ? '1 : slow_sum[DUTY_W-1:0];
        end
        else
        begin
            stepped = clamped;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        period_count_next = period_count_reg;
        held_cmd_next     = held_cmd_reg;
        duty_next         = duty_reg;
        res.motor_action  = ACT_NONE;
        res.motor_duty    = '0;
        res.report_valid  = 1'b0;
        res.speed_report  = '0;

        if (step)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (CMP_W'(period_count_reg) < CMP_W'(cfg.control_period)
                        && period_count_reg != CNT_MAX)
                    begin
                        period_count_next = period_count_reg + 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_CTRL;
                    end
                    if (cmd_valid)
                    begin
                        held_cmd_next = cmd_byte;
                        phase_next    = PH_RECV;
                    end
                end
                PH_CTRL:
                begin
                    phase_next = PH_WAIT;
                    if (held_cmd_reg inside {CMD_OFF, CMD_REVERSE, CMD_FORWARD})
                    begin
                        period_count_next = '0;
                        held_cmd_next     = '0;
                        duty_next         = cfg.restart_duty;
                        if (held_cmd_reg == CMD_OFF)
                        begin
                            res.motor_action = ACT_OFF;
                        end
                        else
                        begin
                            res.motor_action = (held_cmd_reg == CMD_REVERSE)
                                               ? ACT_REVERSE : ACT_FORWARD;
                            res.motor_duty   = cfg.manual_duty;
                        end
                    end
                    else
                    begin
                        duty_next         = stepped;
                        period_count_next = '0;
                        res.motor_action  = ACT_FORWARD;
                        res.motor_duty    = stepped;
                        res.report_valid  = 1'b1;
                        res.speed_report  = {speed_now[5:0], 2'b00};
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_WAIT;
            period_count_reg <= '0;
            held_cmd_reg     <= '0;
            duty_reg         <= RESTART_DUTY_RST;
        end
        else
        begin
            phase_reg        <= phase_next;
            period_count_reg <= period_count_next;
            held_cmd_reg     <= held_cmd_next;
            duty_reg         <= duty_next;
        end
    end

endmodule

FILE: sv/hall_speed_cruise_controller.sv
// timing: a result is registered and appears on the result channel in the cycle after its tick transaction
// throughput: one tick transaction per cycle; the result register frees itself on the
//   same edge it is read, so a stalled result holds off new ticks only while it waits
// reset: rst_n clears all counters, the drive phase and the held command, sets the
//   duty to 230 and loads every configuration register with its default value
module hall_speed_cruise_controller #(
    parameter int COUNT_WIDTH = hscc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    hscc_tick_if.sink                       tick,
    hscc_result_if.source                   result,
    input  logic                            wr_en,
    input  logic [hscc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [hscc_pkg::CFG_DATA_W-1:0] wr_data
);
    import hscc_pkg::*;

    cfg_t                   cfg;
    result_t                res;
    result_t                res_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   step;
    logic [COUNT_WIDTH-1:0] speed_now;

    // a tick is taken whenever the result register is empty or being drained
    assign tick.ready = !out_valid_reg || result.ready;
    assign step       = tick.valid && tick.ready;

    hscc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // falling-edge pulse counter and measure window
    hscc_speed_meter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_meter (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .hall_level     (tick.hall_level),
        .measure_window (cfg.measure_window),
        .speed_now      (speed_now)
    );

    // control period, command handling and duty stepping
    hscc_drive_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_drive (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cmd_valid (tick.cmd_valid),
        .cmd_byte  (tick.cmd_byte),
        .cfg       (cfg),
        .speed_now (speed_now),
        .res       (res)
    );

    // result register
    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.motor_action = res_reg.motor_action;
    assign result.motor_duty   = res_reg.motor_duty;
    assign result.report_valid = res_reg.report_valid;
    assign result.speed_report = res_reg.speed_report;

    // every accepted tick leaves a result waiting in the next cycle
    a_tick_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg
    ) else $error("tick transaction produced no result");

    // speed reports come only with a closed-loop forward step
    a_report_is_forward: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.report_valid) |-> (res_reg.motor_action == ACT_FORWARD)
    ) else $error("speed report without forward action");

    // no duty with action none or off, no report value without a report
    a_unused_fields_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((res_reg.motor_action == ACT_FORWARD || res_reg.motor_action == ACT_REVERSE
              || res_reg.motor_duty == '0)
             && (res_reg.report_valid || res_reg.speed_report == '0))
    ) else $error("unused result field not zero");

endmodule
